### hdl/half_float_add_mul_div_unit_defines.svh
// Assertion macros shared by the binary16 arithmetic unit.
`ifndef HALF_FLOAT_ADD_MUL_DIV_UNIT_DEFINES_SVH
`define HALF_FLOAT_ADD_MUL_DIV_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFAMD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HFAMD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hdl/hfamd_pkg.sv
package hfamd_pkg;

   localparam logic [15:0] SIGN_MASK = 16'h8000;
   localparam logic [15:0] EXP_MASK  = 16'h7C00;
   localparam logic [15:0] QNAN      = 16'h7E00;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Normalized significand with its leading one at bit 10.
   typedef struct packed {
      logic [10:0]        sig;
      logic signed [6:0]  expo;
   } unpk_type;

   typedef struct packed {
      op_type             kind;
      logic               special;
      logic [15:0]        special_bits;
      logic               sign_a;
      logic               sign_b;
      logic               a_bigger;
      unpk_type           ua;
      unpk_type           ub;
   } dec_type;

   typedef struct packed {
      op_type             kind;
      logic               special;
      logic [15:0]        special_bits;
      logic               sign;
      logic [24:0]        mag;
      logic signed [8:0]  expo;
      logic [11:0]        rem;
      logic [10:0]        divisor;
      logic [15:0]        quo;
   } work_type;

   typedef struct packed {
      logic               special;
      logic [15:0]        special_bits;
      logic               sign;
      logic [24:0]        mag;
      logic signed [8:0]  be;
      logic               subn;
      logic               ovf;
      logic               left;
      logic [3:0]         lamt;
      logic [4:0]         ramt;
   } norm_type;

   typedef struct packed {
      logic               special;
      logic [15:0]        special_bits;
      logic               sign;
      logic signed [8:0]  be;
      logic               subn;
      logic               ovf;
      logic [10:0]        q;
      logic               guard;
      logic               sticky;
   } rnd_type;

endpackage

### hdl/half_float_add_mul_div_unit.sv
// Binary16 add, subtract, multiply and divide, round to nearest even.
// Input channel: req_valid/req_ready carry req_operation (0 add, 1 subtract,
// 2 multiply, 3 divide) with req_left_operand and req_right_operand.
// Result channel: rsp_valid/rsp_ready carry rsp_result_bits, one result per
// transaction, in the order the transactions were taken.
// From acceptance to rsp_valid a transaction passes decode, operate, four
// divider stages of four quotient bits each, leading-one search, alignment
// shift and rounding into the output register. Add and multiply ride through
// the divider stages unchanged, so all operations share the same latency.
// Throughput is one transaction per cycle unless a waiting result stalls the
// pipeline; each of the four divider stages performs four radix-2 steps.
// Reset clears every stage valid bit; data registers are not reset.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is dropped or repeated.
`include "half_float_add_mul_div_unit_defines.svh"

module half_float_add_mul_div_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_left_operand,
   input  logic [15:0] req_right_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_bits
);

   logic [8:0]           vld_ff;
   logic                 adv;
   hfamd_pkg::dec_type   dec_in, dec_ff;
   hfamd_pkg::work_type  work_in [5];
   hfamd_pkg::work_type  work_ff [5];
   hfamd_pkg::norm_type  norm_in, norm_ff;
   hfamd_pkg::rnd_type   rnd_in, rnd_ff;
   logic [15:0]          res_in, res_ff;

   // Decode signals.
   logic [15:0] op_a, op_b;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;

   // Operate-stage signals.
   hfamd_pkg::unpk_type   big, small_op;
   logic                  big_sign;
   logic signed [6:0]     exp_diff;
   logic [4:0]            shamt;
   logic [55:0]           align_wide;
   logic [23:0]           small24, big24;

   // Normalize-stage signals.
   logic [24:0]          mag_eff;
   logic [4:0]           top;
   logic signed [8:0]    be, sh, neg_sh;

   // Shift-stage signals.
   logic [24:0]          shl;
   logic [56:0]          shr;

   // Round-stage signals.
   logic                 inc;
   logic [11:0]          r12;
   logic signed [8:0]    be_fin;
   logic signed [8:0]    exp_field;

   function automatic hfamd_pkg::unpk_type unpack16(input logic [15:0] v);
      hfamd_pkg::unpk_type u;
      logic [3:0]          msb;
      msb = '0;
      for (int i = 0; i < 10; i++) begin
         if (v[i]) msb = 4'(i);
      end
      if (v[14:10] == 5'd0) begin
         u.sig  = v[10:0] << (4'd10 - msb);
         u.expo = $signed({3'b000, msb}) - 7'sd34;
      end else begin
         u.sig  = {1'b1, v[9:0]};
         u.expo = $signed({2'b00, v[14:10]}) - 7'sd25;
      end
      return u;
   endfunction

   // Four restoring division steps; the remainder stays below twice the divisor.
   function automatic hfamd_pkg::work_type div4(input hfamd_pkg::work_type w);
      hfamd_pkg::work_type r;
      logic                qbit;
      r = w;
      for (int i = 0; i < 4; i++) begin
         qbit = (r.rem >= {1'b0, r.divisor});
         if (qbit) r.rem = r.rem - {1'b0, r.divisor};
         r.quo = {r.quo[14:0], qbit};
         r.rem = {r.rem[10:0], 1'b0};
      end
      return r;
   endfunction

   assign adv       = !vld_ff[8] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[8];
   assign rsp_result_bits = res_ff;

   // Stage 1: classify operands, settle special results, normalize subnormals.
   always_comb begin
      op_a = req_left_operand;
      op_b = req_right_operand ^ ((hfamd_pkg::op_type'(req_operation) == hfamd_pkg::OP_SUB)
                                  ? hfamd_pkg::SIGN_MASK : 16'h0000);
      a_nan  = (op_a[14:10] == 5'h1f) && (op_a[9:0] != 10'd0);
      b_nan  = (op_b[14:10] == 5'h1f) && (op_b[9:0] != 10'd0);
      a_inf  = (op_a[14:10] == 5'h1f) && (op_a[9:0] == 10'd0);
      b_inf  = (op_b[14:10] == 5'h1f) && (op_b[9:0] == 10'd0);
      a_zero = (op_a[14:0] == 15'd0);
      b_zero = (op_b[14:0] == 15'd0);
      sx     = op_a[15] ^ op_b[15];

      dec_in.sign_a   = op_a[15];
      dec_in.sign_b   = op_b[15];
      dec_in.a_bigger = (op_a[14:0] >= op_b[14:0]);
      dec_in.ua       = unpack16(op_a);
      dec_in.ub       = unpack16(op_b);
      dec_in.special      = 1'b1;
      dec_in.special_bits = hfamd_pkg::QNAN;

      case (req_operation) inside
         hfamd_pkg::OP_ADD, hfamd_pkg::OP_SUB: begin
            dec_in.kind = hfamd_pkg::OP_ADD;
            if (a_nan || b_nan || (a_inf && b_inf && sx)) dec_in.special_bits = hfamd_pkg::QNAN;
            else if (a_inf)  dec_in.special_bits = op_a;
            else if (b_inf)  dec_in.special_bits = op_b;
            else if (a_zero) dec_in.special_bits = op_b;
            else if (b_zero) dec_in.special_bits = op_a;
            // Equal magnitudes of opposite sign cancel to plus zero.
            else if (op_a[14:0] == op_b[14:0] && sx) dec_in.special_bits = 16'h0000;
            else dec_in.special = 1'b0;
         end
         hfamd_pkg::OP_MUL: begin
            dec_in.kind = hfamd_pkg::OP_MUL;
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
               dec_in.special_bits = hfamd_pkg::QNAN;
            else if (a_inf || b_inf)
               dec_in.special_bits = {sx, 15'h7C00};
            else if (a_zero || b_zero)
               dec_in.special_bits = {sx, 15'h0000};
            else dec_in.special = 1'b0;
         end
         default: begin
            dec_in.kind = hfamd_pkg::OP_DIV;
            if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf))
               dec_in.special_bits = hfamd_pkg::QNAN;
            else if (a_inf || b_zero)
               dec_in.special_bits = {sx, 15'h7C00};
            else if (a_zero || b_inf)
               dec_in.special_bits = {sx, 15'h0000};
            else dec_in.special = 1'b0;
         end
      endcase
   end

   // Stage 2: aligned add, significand product, or divider setup.
   always_comb begin
      big      = dec_ff.a_bigger ? dec_ff.ua : dec_ff.ub;
      small_op = dec_ff.a_bigger ? dec_ff.ub : dec_ff.ua;
      big_sign = dec_ff.a_bigger ? dec_ff.sign_a : dec_ff.sign_b;
      exp_diff = big.expo - small_op.expo;
      shamt    = (exp_diff > 7'sd31) ? 5'd31 : exp_diff[4:0];
      align_wide = {small_op.sig, 45'd0} >> shamt;
      // Bits shifted past the guard field are folded into a sticky bit.
      small24  = align_wide[55:32] | {23'd0, |align_wide[31:0]};
      big24    = {big.sig, 13'd0};

      work_in[0].kind         = dec_ff.kind;
      work_in[0].special      = dec_ff.special;
      work_in[0].special_bits = dec_ff.special_bits;
      work_in[0].rem          = {1'b0, dec_ff.ua.sig};
      work_in[0].divisor      = dec_ff.ub.sig;
      work_in[0].quo          = '0;
      work_in[0].sign         = dec_ff.sign_a ^ dec_ff.sign_b;
      case (dec_ff.kind)
         hfamd_pkg::OP_ADD: begin
            work_in[0].sign = big_sign;
            work_in[0].mag  = (dec_ff.sign_a == dec_ff.sign_b)
                              ? ({1'b0, big24} + {1'b0, small24})
                              : ({1'b0, big24} - {1'b0, small24});
            work_in[0].expo = 9'(big.expo) - 9'sd13;
         end
         hfamd_pkg::OP_MUL: begin
            work_in[0].mag  = {3'd0, {11'd0, dec_ff.ua.sig} * {11'd0, dec_ff.ub.sig}};
            work_in[0].expo = 9'(dec_ff.ua.expo) + 9'(dec_ff.ub.expo);
         end
         default: begin
            work_in[0].mag  = '0;
            work_in[0].expo = 9'(dec_ff.ua.expo) - 9'(dec_ff.ub.expo) - 9'sd16;
         end
      endcase
   end

   // Stages 3 to 6: sixteen quotient bits, four per stage.
   always_comb begin
      work_in[1] = div4(work_ff[0]);
      work_in[2] = div4(work_ff[1]);
      work_in[3] = div4(work_ff[2]);
      work_in[4] = div4(work_ff[3]);
   end

   // Stage 7: leading-one search and choice of rounding position.
   always_comb begin
      mag_eff = (work_ff[4].kind == hfamd_pkg::OP_DIV)
                ? {8'd0, work_ff[4].quo, |work_ff[4].rem} : work_ff[4].mag;
      top = '0;
      for (int i = 0; i < 25; i++) begin
         if (mag_eff[i]) top = 5'(i);
      end
      be = work_ff[4].expo + $signed({4'b0000, top});
      norm_in.subn = (be < -9'sd14);
      sh = norm_in.subn ? (-work_ff[4].expo - 9'sd24) : ($signed({4'b0000, top}) - 9'sd10);
      neg_sh = -sh;
      norm_in.special      = work_ff[4].special;
      norm_in.special_bits = work_ff[4].special_bits;
      norm_in.sign         = work_ff[4].sign;
      norm_in.mag          = mag_eff;
      norm_in.be           = be;
      norm_in.ovf          = (be > 9'sd15);
      norm_in.left         = (sh < 9'sd0);
      norm_in.lamt         = neg_sh[3:0];
      norm_in.ramt         = (sh > 9'sd27) ? 5'd27 : sh[4:0];
   end

   // Stage 8: shift to eleven kept bits with guard and sticky.
   always_comb begin
      shl = norm_ff.mag << norm_ff.lamt;
      shr = {norm_ff.mag, 32'd0} >> norm_ff.ramt;
      rnd_in.special      = norm_ff.special;
      rnd_in.special_bits = norm_ff.special_bits;
      rnd_in.sign         = norm_ff.sign;
      rnd_in.be           = norm_ff.be;
      rnd_in.subn         = norm_ff.subn;
      rnd_in.ovf          = norm_ff.ovf;
      if (norm_ff.left) begin
         rnd_in.q      = shl[10:0];
         rnd_in.guard  = 1'b0;
         rnd_in.sticky = 1'b0;
      end else begin
         rnd_in.q      = shr[42:32];
         rnd_in.guard  = shr[31];
         rnd_in.sticky = |shr[30:0];
      end
   end

   // Stage 9: round to nearest even and pack.
   always_comb begin
      inc       = rnd_ff.guard && (rnd_ff.sticky || rnd_ff.q[0]);
      r12       = {1'b0, rnd_ff.q} + {11'd0, inc};
      be_fin    = rnd_ff.be + $signed({8'd0, r12[11]});
      exp_field = be_fin + 9'sd15;
      if (rnd_ff.special) begin
         res_in = rnd_ff.special_bits;
      end else if (rnd_ff.subn) begin
         // Rounding up to 0x400 lands exactly on the smallest normal.
         res_in = {rnd_ff.sign, 4'd0, r12[10:0]};
      end else if (rnd_ff.ovf || be_fin > 9'sd15) begin
         res_in = {rnd_ff.sign, 15'h7C00};
      end else begin
         res_in = {rnd_ff.sign, exp_field[4:0], r12[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[7:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dec_ff  <= dec_in;
         for (int k = 0; k < 5; k++) begin
            work_ff[k] <= work_in[k];
         end
         norm_ff <= norm_in;
         rnd_ff  <= rnd_in;
         res_ff  <= res_in;
      end
   end

   `HFAMD_ASSERT_SAME(nan_is_canonical, rsp_valid && (rsp_result_bits[14:10] == 5'h1f) && (rsp_result_bits[9:0] != 10'd0), rsp_result_bits == hfamd_pkg::QNAN)
   `HFAMD_ASSERT_NEXT(stall_freezes_pipe, rsp_valid && !rsp_ready, $stable(vld_ff))
   `HFAMD_ASSERT_NEXT(accept_enters_pipe, req_valid && req_ready, vld_ff[0])
   `HFAMD_ASSERT_SAME(subnormal_round_bound, vld_ff[7] && !rnd_ff.special && rnd_ff.subn, r12 <= 12'd1024)

endmodule

### test/tb_half_float_add_mul_div_unit.sv
`timescale 1ns / 1ps

module tb_half_float_add_mul_div_unit;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 800;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [15:0] req_left_operand;
   logic [15:0] req_right_operand;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_result_bits;

   half_float_add_mul_div_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_left_operand(req_left_operand),
      .req_right_operand(req_right_operand),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_bits(rsp_result_bits)
   );

   typedef struct {
      hfamd_pkg::op_type op;
      logic [15:0]       a;
      logic [15:0]       b;
      logic              known;
      logic [15:0]       want;
   } vector_type;

   logic [15:0] pending_results[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          sent_count = 0;
   int          cycle_count = 0;
   bit          long_hold = 0;
   int          op_seen[4];

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Predictor helpers working on wide integer significands.
   function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
      logic [63:0] q, rem, half;
      if (sh <= 0) begin
         if (sh <= -64) return 0;
         return v << (-sh);
      end
      if (sh > 64) return 0;
      if (sh == 64) return (v > (64'd1 << 63)) ? 64'd1 : 64'd0;
      q = v >> sh;
      rem = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return q;
   endfunction

   function automatic logic [15:0] pack_half(logic neg, logic [63:0] sig, int ex);
      logic [15:0] sgn;
      int top, be;
      logic [63:0] r;
      sgn = neg ? hfamd_pkg::SIGN_MASK : 16'h0000;
      if (sig == 0) return sgn;
      top = -1;
      for (int i = 0; i < 64; i++) if (sig[i]) top = i;
      be = ex + top;
      if (be < -14) begin
         r = round_shift(sig, -(ex + 24));
         if (r == 0) return sgn;
         if (r >= 64'h400) return sgn | 16'h0400;
         return sgn | r[15:0];
      end
      if (be > 15) return sgn | hfamd_pkg::EXP_MASK;
      r = round_shift(sig, top - 10);
      if (r == 64'h800) begin
         r = 64'h400;
         be++;
      end
      if (be > 15) return sgn | hfamd_pkg::EXP_MASK;
      return sgn | 16'((be + 15) << 10) | (r[15:0] & 16'h03FF);
   endfunction

   function automatic logic is_nan(logic [15:0] v);
      return v[14:10] == 5'h1F && v[9:0] != 0;
   endfunction

   function automatic logic is_inf(logic [15:0] v);
      return v[14:10] == 5'h1F && v[9:0] == 0;
   endfunction

   function automatic logic is_zero(logic [15:0] v);
      return v[14:0] == 0;
   endfunction

   function automatic logic [63:0] sig_of(logic [15:0] v);
      return (v[14:10] == 0) ? {54'd0, v[9:0]} : {53'd0, 1'b1, v[9:0]};
   endfunction

   function automatic int exp_of(logic [15:0] v);
      return (v[14:10] == 0) ? -24 : int'(v[14:10]) - 25;
   endfunction

   function automatic logic [15:0] half_sum(logic [15:0] a, logic [15:0] b);
      logic [63:0] ma, mb;
      int ea, eb, ec;
      if (is_nan(a) || is_nan(b)) return hfamd_pkg::QNAN;
      if (is_inf(a) || is_inf(b)) begin
         if (is_inf(a) && is_inf(b) && a[15] != b[15]) return hfamd_pkg::QNAN;
         return is_inf(a) ? a : b;
      end
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      ea = exp_of(a);
      eb = exp_of(b);
      ec = (ea < eb) ? ea : eb;
      ma = sig_of(a) << (ea - ec);
      mb = sig_of(b) << (eb - ec);
      if (a[15] == b[15]) return pack_half(a[15], ma + mb, ec);
      if (ma == mb) return 16'h0000;
      if (ma > mb) return pack_half(a[15], ma - mb, ec);
      return pack_half(b[15], mb - ma, ec);
   endfunction

   function automatic logic [15:0] half_product(logic [15:0] a, logic [15:0] b);
      logic neg;
      neg = a[15] ^ b[15];
      if (is_nan(a) || is_nan(b)) return hfamd_pkg::QNAN;
      if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return hfamd_pkg::QNAN;
      if (is_inf(a) || is_inf(b)) return {neg, 15'h7C00};
      if (is_zero(a) || is_zero(b)) return {neg, 15'h0};
      return pack_half(neg, sig_of(a) * sig_of(b), exp_of(a) + exp_of(b));
   endfunction

   function automatic logic [15:0] half_quotient(logic [15:0] a, logic [15:0] b);
      logic neg;
      logic [63:0] num, q;
      neg = a[15] ^ b[15];
      if (is_nan(a) || is_nan(b)) return hfamd_pkg::QNAN;
      if ((is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b))) return hfamd_pkg::QNAN;
      if (is_inf(a) || is_zero(b)) return {neg, 15'h7C00};
      if (is_zero(a) || is_inf(b)) return {neg, 15'h0};
      num = sig_of(a) << 42;
      q = num / sig_of(b);
      if (num % sig_of(b) != 0) q[0] = 1'b1;
      return pack_half(neg, q, exp_of(a) - exp_of(b) - 42);
   endfunction

   function automatic logic [15:0] half_result(hfamd_pkg::op_type op, logic [15:0] a,
                                               logic [15:0] b);
      case (op)
         hfamd_pkg::OP_ADD: return half_sum(a, b);
         hfamd_pkg::OP_SUB: return half_sum(a, b ^ hfamd_pkg::SIGN_MASK);
         hfamd_pkg::OP_MUL: return half_product(a, b);
         default: return half_quotient(a, b);
      endcase
   endfunction

   // Random operand biased toward special encodings and small exponent spreads.
   function automatic logic [15:0] random_half();
      case ($urandom_range(0, 9))
         0: return {$urandom_range(0, 1) == 1, 15'h0};
         1: return {$urandom_range(0, 1) == 1, 15'h7C00};
         2: return {1'($urandom), 5'h1F, 10'($urandom)};
         3: return {1'($urandom), 5'h00, 10'($urandom)};
         4: return {1'($urandom), 5'($urandom_range(12, 18)), 10'($urandom)};
         5: return {1'($urandom), 5'($urandom_range(28, 30)), 10'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_one(hfamd_pkg::op_type op, logic [15:0] a, logic [15:0] b,
                           logic [15:0] want);
      req_valid <= 1'b1;
      req_operation <= op;
      req_left_operand <= a;
      req_right_operand <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(want);
      op_seen[op]++;
      sent_count++;
      @(negedge clock);
   endtask

   task automatic pause_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   vector_type directed[] = '{
      '{hfamd_pkg::OP_ADD, 16'h3C00, 16'h3C00, 1'b1, 16'h4000},
      '{hfamd_pkg::OP_SUB, 16'h3C00, 16'h3C00, 1'b1, 16'h0000},
      '{hfamd_pkg::OP_MUL, 16'h4000, 16'h4200, 1'b1, 16'h4600},
      '{hfamd_pkg::OP_DIV, 16'h4600, 16'h4000, 1'b1, 16'h4200},
      '{hfamd_pkg::OP_ADD, 16'h7E01, 16'h3C00, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_DIV, 16'hFFFF, 16'h0000, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_ADD, 16'h7C00, 16'hFC00, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_SUB, 16'h7C00, 16'h7C00, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_ADD, 16'hFC00, 16'hFC00, 1'b1, 16'hFC00},
      '{hfamd_pkg::OP_ADD, 16'h0000, 16'h8000, 1'b1, 16'h8000},
      '{hfamd_pkg::OP_ADD, 16'h8000, 16'h0000, 1'b1, 16'h0000},
      '{hfamd_pkg::OP_ADD, 16'h1234, 16'h8000, 1'b1, 16'h1234},
      '{hfamd_pkg::OP_MUL, 16'h7C00, 16'h8000, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_MUL, 16'hFC00, 16'h3C00, 1'b1, 16'hFC00},
      '{hfamd_pkg::OP_DIV, 16'h0000, 16'h8000, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_DIV, 16'h7C00, 16'hFC00, 1'b1, hfamd_pkg::QNAN},
      '{hfamd_pkg::OP_DIV, 16'hBC00, 16'h0000, 1'b1, 16'hFC00},
      '{hfamd_pkg::OP_DIV, 16'h3C00, 16'hFC00, 1'b1, 16'h8000},
      '{hfamd_pkg::OP_MUL, 16'h7BFF, 16'h7BFF, 1'b1, 16'h7C00},
      '{hfamd_pkg::OP_MUL, 16'h0001, 16'h0001, 1'b1, 16'h0000},
      '{hfamd_pkg::OP_ADD, 16'h7BFF, 16'h7BFF, 1'b1, 16'h7C00},
      '{hfamd_pkg::OP_ADD, 16'h0001, 16'h8001, 1'b1, 16'h0000},
      '{hfamd_pkg::OP_DIV, 16'h0001, 16'h7BFF, 1'b0, 16'h0000},
      '{hfamd_pkg::OP_MUL, 16'h3555, 16'h0401, 1'b0, 16'h0000},
      '{hfamd_pkg::OP_SUB, 16'h0400, 16'h03FF, 1'b0, 16'h0000}
   };

   // Receiver: a random stall pattern, plus a long hold-off each time one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
            long_hold = 0;
         end else if (cycle_count % 512 < 128) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h with nothing outstanding", rsp_result_bits);
         end else begin
            logic [15:0] want;
            want = pending_results.pop_front();
            if (rsp_result_bits !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %h, got %h", want, rsp_result_bits);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int                burst;
      hfamd_pkg::op_type op_r;
      logic [15:0]       a_r;
      logic [15:0]       b_r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = hfamd_pkg::OP_ADD;
      req_left_operand = 16'h0000;
      req_right_operand = 16'h0000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_one(directed[i].op, directed[i].a, directed[i].b,
                  directed[i].known ? directed[i].want
                                    : half_result(directed[i].op, directed[i].a,
                                                  directed[i].b));
      end

      // Sender pauses until everything in flight has come back.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);

      long_hold = 1;
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
            op_r = hfamd_pkg::op_type'($urandom_range(0, 3));
            a_r  = random_half();
            b_r  = random_half();
            send_one(op_r, a_r, b_r, half_result(op_r, a_r, b_r));
         end
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
         if (n > RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 40 && !long_hold)
            long_hold = 1;
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d transactions (add %0d, sub %0d, mul %0d, div %0d), %0d results.",
               sent_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], result_count);
      $display("Mismatch count: %0d", mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
